>>> src/psog_pkg.sv
// ----------------------------------------------------------------------------
// psog_pkg
// Shared types, request and status codes for the site occupancy grid.
// ----------------------------------------------------------------------------
package psog_pkg;

  // default grid dimensions in sites
  localparam int DEF_MAX_COLUMNS = 256;
  localparam int DEF_MAX_ROWS    = 256;

  // request codes
  localparam logic [2:0] REQ_CHECK = 3'd0;
  localparam logic [2:0] REQ_PLACE = 3'd1;
  localparam logic [2:0] REQ_READ  = 3'd2;
  localparam logic [2:0] REQ_SET   = 3'd3;
  localparam logic [2:0] REQ_CLEAR = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BLOCKED = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  // configuration register indexes
  localparam int          CFG_IDX_W        = 3;
  localparam logic [2:0]  CFG_GRID_COLUMNS = 3'd0;
  localparam logic [2:0]  CFG_GRID_ROWS    = 3'd1;
  localparam logic [2:0]  CFG_ORIGIN_X     = 3'd2;
  localparam logic [2:0]  CFG_ORIGIN_Y     = 3'd3;
  localparam logic [2:0]  CFG_PITCH_X      = 3'd4;
  localparam logic [2:0]  CFG_PITCH_Y      = 3'd5;

  // divider geometry: 32-bit dividend, 16-bit divisor, two quotient bits a cycle
  localparam int DIV_NUM_W     = 32;
  localparam int DIV_DEN_W     = 16;
  localparam int DIV_STEP_BITS = 2;

  typedef struct packed {
    logic [8:0]         grid_columns;
    logic [8:0]         grid_rows;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic [15:0]        site_pitch_x;
    logic [15:0]        site_pitch_y;
  } cfg_t;

  typedef struct packed {
    logic [1:0] status;
    logic       site_occupied;
  } res_t;

endpackage

>>> src/psog_ram.sv
// ----------------------------------------------------------------------------
// psog_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module psog_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/psog_div.sv
// ----------------------------------------------------------------------------
// psog_div
// Iterative restoring divider, unsigned, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module psog_div import psog_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] dividend,
  input  logic [DIV_DEN_W-1:0] divisor,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quotient
);

  localparam int STEPS  = DIV_NUM_W / DIV_STEP_BITS;
  localparam int CNT_W  = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [DIV_NUM_W-1:0] num_r, num_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DIV_NUM_W-1:0] num_c;
  logic [DIV_DEN_W-1:0] rem_c;
  logic [DIV_DEN_W:0]   trial_c;

  // quotient bits shift in at the bottom as the dividend shifts out the top
  always_comb begin
    num_c   = num_r;
    rem_c   = rem_r;
    trial_c = '0;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      trial_c = {rem_c, num_c[DIV_NUM_W-1]};
      num_c   = {num_c[DIV_NUM_W-2:0], 1'b0};
      if (trial_c >= {1'b0, den_r}) begin
        rem_c    = DIV_DEN_W'(trial_c - {1'b0, den_r});
        num_c[0] = 1'b1;
      end else begin
        rem_c    = trial_c[DIV_DEN_W-1:0];
      end
    end
  end

  // step control
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
    end else if (busy_r) begin
      num_nxt = num_c;
      rem_nxt = rem_c;
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done     = done_r;
  assign quotient = num_r;

endmodule

>>> src/psog_ctrl.sv
// ----------------------------------------------------------------------------
// psog_ctrl
// Request sequencer: site conversion, range checks and row-wise
// read-modify-write of the occupancy memory.
// ----------------------------------------------------------------------------
module psog_ctrl import psog_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [2:0]              in_req_type,
  input  logic signed [31:0]      in_loc_x,
  input  logic signed [31:0]      in_loc_y,
  input  logic                    in_loc_fractional,
  input  logic [19:0]             in_cell_width,
  input  logic [19:0]             in_cell_height,
  input  logic [7:0]              in_site_col,
  input  logic [7:0]              in_site_row,
  output logic                    res_valid,
  input  logic                    res_ready,
  output res_t                    res,
  output logic                    mem_rd_en,
  output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] mem_rd_addr,
  input  logic [MAX_COLUMNS-1:0]  mem_rd_data,
  output logic                    mem_wr_en,
  output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] mem_wr_addr,
  output logic [MAX_COLUMNS-1:0]  mem_wr_data
);

  localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int NCOL_W = $clog2(MAX_COLUMNS + 1);
  localparam int NROW_W = $clog2(MAX_ROWS + 1);

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_CHK   = 3'd3;
  localparam logic [2:0] S_MASK  = 3'd4;
  localparam logic [2:0] S_WALK  = 3'd5;
  localparam logic [2:0] S_SITE  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]             state_r, state_nxt;
  logic [ROW_W-1:0]       clr_row_r, clr_row_nxt;
  logic [2:0]             req_r, req_nxt;
  logic [7:0]             col_r, col_nxt;
  logic [ROW_W-1:0]       row_r, row_nxt;
  logic                   dx_neg_r, dx_neg_nxt;
  logic                   dy_neg_r, dy_neg_nxt;
  logic [NCOL_W-1:0]      x_lo_r, x_lo_nxt;
  logic [NCOL_W-1:0]      x_end_r, x_end_nxt;
  logic [MAX_COLUMNS-1:0] mask_r, mask_nxt;
  logic [ROW_W-1:0]       rd_row_r, rd_row_nxt;
  logic [NROW_W-1:0]      rd_left_r, rd_left_nxt;
  logic [ROW_W-1:0]       wr_row_r, wr_row_nxt;
  logic                   pend_r, pend_nxt;
  logic                   blocked_r, blocked_nxt;
  res_t                   res_r, res_nxt;

  logic                   in_acc;
  logic [NCOL_W-1:0]      ncol;
  logic [NROW_W-1:0]      nrow;
  logic [15:0]            pitch_x;
  logic [15:0]            pitch_y;
  logic [32:0]            dx;
  logic [32:0]            dy;
  logic                   div_start;
  logic                   dx_done, dy_done, dw_done, dh_done;
  logic                   div_done;
  logic [31:0]            qx, qy, qw, qh;
  logic [32:0]            sum_x;
  logic [32:0]            sum_y;
  logic [COL_W-1:0]       col_idx;
  logic [MAX_COLUMNS-1:0] col_bit;
  logic [MAX_COLUMNS-1:0] mask_c;

  // sites in use and effective pitch
  assign ncol    = (32'(cfg.grid_columns) < 32'(MAX_COLUMNS)) ? NCOL_W'(cfg.grid_columns)
                                                              : NCOL_W'(MAX_COLUMNS);
  assign nrow    = (32'(cfg.grid_rows) < 32'(MAX_ROWS)) ? NROW_W'(cfg.grid_rows)
                                                        : NROW_W'(MAX_ROWS);
  assign pitch_x = (cfg.site_pitch_x == 16'd0) ? 16'd1 : cfg.site_pitch_x;
  assign pitch_y = (cfg.site_pitch_y == 16'd0) ? 16'd1 : cfg.site_pitch_y;

  // offset from the origin, 33-bit signed
  assign dx = {in_loc_x[31], in_loc_x} - {cfg.origin_x[31], cfg.origin_x};
  assign dy = {in_loc_y[31], in_loc_y} - {cfg.origin_y[31], cfg.origin_y};

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // four dividers run side by side: column, row, width and height in sites
  psog_div u_div_x (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dx[31:0]),
    .divisor(pitch_x), .done(dx_done), .quotient(qx)
  );
  psog_div u_div_y (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dy[31:0]),
    .divisor(pitch_y), .done(dy_done), .quotient(qy)
  );
  psog_div u_div_w (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(32'(in_cell_width)),
    .divisor(pitch_x), .done(dw_done), .quotient(qw)
  );
  psog_div u_div_h (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(32'(in_cell_height)),
    .divisor(pitch_y), .done(dh_done), .quotient(qh)
  );

  assign div_done = dx_done && dy_done && dw_done && dh_done;

  // far edge of the rectangle in sites
  assign sum_x = {1'b0, qx} + {1'b0, qw};
  assign sum_y = {1'b0, qy} + {1'b0, qh};

  // single-site bit select
  assign col_idx = COL_W'(col_r);
  assign col_bit = MAX_COLUMNS'(1) << col_idx;

  // column mask of the rectangle
  always_comb begin
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      mask_c[c] = (NCOL_W'(c) >= x_lo_r) && (NCOL_W'(c) < x_end_r);
    end
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_row_nxt = clr_row_r;
    req_nxt     = req_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    dx_neg_nxt  = dx_neg_r;
    dy_neg_nxt  = dy_neg_r;
    x_lo_nxt    = x_lo_r;
    x_end_nxt   = x_end_r;
    mask_nxt    = mask_r;
    rd_row_nxt  = rd_row_r;
    rd_left_nxt = rd_left_r;
    wr_row_nxt  = wr_row_r;
    pend_nxt    = 1'b0;
    blocked_nxt = blocked_r;
    res_nxt     = res_r;
    div_start   = 1'b0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = rd_row_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = wr_row_r;
    mem_wr_data = mem_rd_data | mask_r;
    res_valid   = 1'b0;

    case (state_r)
      // zero one row per cycle after reset
      S_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_row_r;
        mem_wr_data = '0;
        clr_row_nxt = clr_row_r + ROW_W'(1);
        if (clr_row_r == ROW_W'(MAX_ROWS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      // take a request
      S_IDLE: begin
        if (in_acc) begin
          req_nxt               = in_req_type;
          col_nxt               = in_site_col;
          row_nxt               = ROW_W'(in_site_row);
          dx_neg_nxt            = dx[32];
          dy_neg_nxt            = dy[32];
          res_nxt.site_occupied = 1'b0;
          case (in_req_type)
            REQ_CHECK, REQ_PLACE: begin
              if (in_req_type == REQ_CHECK && in_loc_fractional) begin
                res_nxt.status = ST_BLOCKED;
                state_nxt      = S_DONE;
              end else begin
                div_start = 1'b1;
                state_nxt = S_DIV;
              end
            end
            REQ_READ, REQ_SET, REQ_CLEAR: begin
              if (32'(in_site_col) >= 32'(ncol) || 32'(in_site_row) >= 32'(nrow)) begin
                res_nxt.status = ST_RANGE;
                state_nxt      = S_DONE;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = ROW_W'(in_site_row);
                state_nxt   = S_SITE;
              end
            end
            default: begin
              res_nxt.status = ST_RANGE;
              state_nxt      = S_DONE;
            end
          endcase
        end
      end

      // wait for the site conversion
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_CHK;
        end
      end

      // empty rectangle, negative offset, reach past the grid
      S_CHK: begin
        if (qw == 32'd0 || qh == 32'd0) begin
          res_nxt.status = ST_OK;
          state_nxt      = S_DONE;
        end else if (dx_neg_r || dy_neg_r) begin
          res_nxt.status = ST_RANGE;
          state_nxt      = S_DONE;
        end else if (sum_x > 33'(ncol) || sum_y > 33'(nrow)) begin
          res_nxt.status = ST_RANGE;
          state_nxt      = S_DONE;
        end else begin
          x_lo_nxt    = NCOL_W'(qx);
          x_end_nxt   = NCOL_W'(sum_x);
          rd_row_nxt  = ROW_W'(qy);
          rd_left_nxt = NROW_W'(qh);
          blocked_nxt = 1'b0;
          state_nxt   = S_MASK;
        end
      end

      S_MASK: begin
        mask_nxt  = mask_c;
        state_nxt = S_WALK;
      end

      // read row n while row n-1 is checked or written back
      S_WALK: begin
        if (rd_left_r != '0) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = rd_row_r;
          rd_row_nxt  = rd_row_r + ROW_W'(1);
          rd_left_nxt = rd_left_r - NROW_W'(1);
          wr_row_nxt  = rd_row_r;
          pend_nxt    = 1'b1;
        end
        if (pend_r) begin
          if (req_r == REQ_PLACE) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = wr_row_r;
            mem_wr_data = mem_rd_data | mask_r;
          end else if ((mem_rd_data & mask_r) != '0) begin
            blocked_nxt = 1'b1;
          end
        end
        if (rd_left_r == '0 && !pend_r) begin
          res_nxt.status = (req_r == REQ_CHECK && blocked_r) ? ST_BLOCKED : ST_OK;
          state_nxt      = S_DONE;
        end
      end

      // single-site read, set or clear
      S_SITE: begin
        res_nxt.status = ST_OK;
        mem_wr_addr    = row_r;
        case (req_r)
          REQ_READ: begin
            res_nxt.site_occupied = mem_rd_data[col_idx];
          end
          REQ_SET: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = mem_rd_data | col_bit;
          end
          default: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = mem_rd_data & ~col_bit;
          end
        endcase
        state_nxt = S_DONE;
      end

      // hand the result to the output register
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_row_r <= '0;
      pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_row_r <= clr_row_nxt;
      pend_r    <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    col_r     <= col_nxt;
    row_r     <= row_nxt;
    dx_neg_r  <= dx_neg_nxt;
    dy_neg_r  <= dy_neg_nxt;
    x_lo_r    <= x_lo_nxt;
    x_end_r   <= x_end_nxt;
    mask_r    <= mask_nxt;
    rd_row_r  <= rd_row_nxt;
    rd_left_r <= rd_left_nxt;
    wr_row_r  <= wr_row_nxt;
    blocked_r <= blocked_nxt;
    res_r     <= res_nxt;
  end

  assign res = res_r;

  // no row is read and written back in the same cycle
  a_no_rw_same_row: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_rd_en && mem_wr_en && mem_rd_addr == mem_wr_addr))
    else $error("occupancy row read and written in the same cycle");

  // conversion results only arrive while the sequencer waits for them
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside the conversion wait");

  // the row walk issues exactly one read per cycle until done
  a_walk_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && rd_left_r != '0) |=>
      (rd_left_r == $past(rd_left_r) - NROW_W'(1)) && pend_r)
    else $error("row walk stalled or skipped a row");

endmodule

>>> src/placement_site_occupancy_grid_top.sv
// ----------------------------------------------------------------------------
// placement_site_occupancy_grid_top
// Occupancy bitmap with rectangle check/place and single-site access.
// ----------------------------------------------------------------------------
// After reset the block clears its bitmap one row per cycle and holds
// in_stall high meanwhile; configuration writes are taken at any
// time. Requests are handled one at a time. A rectangle request waits
// on the divider that turns location and extent into sites (16 steps
// of two quotient bits, then the done flag), then walks the covered rows
// through the single memory read port at one row per cycle; an empty or
// out-of-range rectangle stops after the range checks. A check with a
// fractional location goes straight to its result, and a single-site
// request reads its row first. The result register lets the next
// request start while a result waits on out_stall.
module placement_site_occupancy_grid_top import psog_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           in_req_type,
  input  logic signed [31:0]   in_loc_x,
  input  logic signed [31:0]   in_loc_y,
  input  logic                 in_loc_fractional,
  input  logic [19:0]          in_cell_width,
  input  logic [19:0]          in_cell_height,
  input  logic [7:0]           in_site_col,
  input  logic [7:0]           in_site_row,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_status,
  output logic                 out_site_occupied,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  cfg_t                   cfg_r, cfg_nxt;
  logic                   out_valid_r, out_valid_nxt;
  res_t                   out_res_r, out_res_nxt;
  logic                   res_valid;
  logic                   res_ready;
  res_t                   res;
  logic                   mem_rd_en;
  logic [ROW_W-1:0]       mem_rd_addr;
  logic [MAX_COLUMNS-1:0] mem_rd_data;
  logic                   mem_wr_en;
  logic [ROW_W-1:0]       mem_wr_addr;
  logic [MAX_COLUMNS-1:0] mem_wr_data;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRID_COLUMNS: cfg_nxt.grid_columns = cfg_data[8:0];
        CFG_GRID_ROWS:    cfg_nxt.grid_rows    = cfg_data[8:0];
        CFG_ORIGIN_X:     cfg_nxt.origin_x     = cfg_data;
        CFG_ORIGIN_Y:     cfg_nxt.origin_y     = cfg_data;
        CFG_PITCH_X:      cfg_nxt.site_pitch_x = cfg_data[15:0];
        CFG_PITCH_Y:      cfg_nxt.site_pitch_y = cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_columns <= 9'd256;
      cfg_r.grid_rows    <= 9'd256;
      cfg_r.origin_x     <= '0;
      cfg_r.origin_y     <= '0;
      cfg_r.site_pitch_x <= 16'd1;
      cfg_r.site_pitch_y <= 16'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // occupancy memory, one row of sites per word
  psog_ram #(
    .WIDTH(MAX_COLUMNS),
    .DEPTH(MAX_ROWS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  psog_ctrl #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_loc_x          (in_loc_x),
    .in_loc_y          (in_loc_y),
    .in_loc_fractional (in_loc_fractional),
    .in_cell_width     (in_cell_width),
    .in_cell_height    (in_cell_height),
    .in_site_col       (in_site_col),
    .in_site_row       (in_site_row),
    .res_valid         (res_valid),
    .res_ready         (res_ready),
    .res               (res),
    .mem_rd_en         (mem_rd_en),
    .mem_rd_addr       (mem_rd_addr),
    .mem_rd_data       (mem_rd_data),
    .mem_wr_en         (mem_wr_en),
    .mem_wr_addr       (mem_wr_addr),
    .mem_wr_data       (mem_wr_data)
  );

  // result output register
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_res_r.status;
  assign out_site_occupied = out_res_r.site_occupied;

  // a new result shows only after the sequencer offered one
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(res_valid))
    else $error("result appeared without a finished request");

endmodule

>>> verif/grid_occupancy_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_occupancy_checker
// Watches the request, result and register channels of the site occupancy
// grid, keeps a shadow bitmap and register set, works out the status of each
// accepted request and compares it with what comes out, in order.
// ----------------------------------------------------------------------------
module grid_occupancy_checker import psog_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [2:0]           in_req_type,
  input  logic signed [31:0]   in_loc_x,
  input  logic signed [31:0]   in_loc_y,
  input  logic                 in_loc_fractional,
  input  logic [19:0]          in_cell_width,
  input  logic [19:0]          in_cell_height,
  input  logic [7:0]           in_site_col,
  input  logic [7:0]           in_site_row,
  // result channel
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [1:0]           out_status,
  input  logic                 out_site_occupied,
  // register write channel
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  // to the testbench top
  output int                   verdicts_waiting,
  output int                   mismatches
);

  // shadow registers and bitmap
  cfg_t                 grid;
  bit [MAX_COLUMNS-1:0] occ_rows [MAX_ROWS];
  res_t                 pending_verdicts [$];
  res_t                 oldest;
  int                   err_total = 0;
  int                   results_seen = 0;

  assign mismatches = err_total;

  // one line per mismatch
  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    err_total++;
  endtask

  // status of one request; place, set and clear update the shadow bitmap
  function automatic res_t resolve_request(input logic [2:0] kind,
                                           input logic signed [31:0] lx,
                                           input logic signed [31:0] ly,
                                           input logic frac,
                                           input logic [19:0] cw,
                                           input logic [19:0] ch,
                                           input logic [7:0] col,
                                           input logic [7:0] row);
    res_t   v;
    longint ncol, nrow, px, py, w, h, dx, dy, x0, y0;
    v.status = ST_OK;
    v.site_occupied = 1'b0;
    ncol = (grid.grid_columns < MAX_COLUMNS) ? grid.grid_columns : MAX_COLUMNS;
    nrow = (grid.grid_rows < MAX_ROWS) ? grid.grid_rows : MAX_ROWS;
    if (kind == REQ_CHECK || kind == REQ_PLACE) begin
      // a zero pitch behaves as one
      px = (grid.site_pitch_x == 16'd0) ? 1 : grid.site_pitch_x;
      py = (grid.site_pitch_y == 16'd0) ? 1 : grid.site_pitch_y;
      w = cw / px;
      h = ch / py;
      dx = longint'($signed(lx)) - longint'($signed(grid.origin_x));
      dy = longint'($signed(ly)) - longint'($signed(grid.origin_y));
      if (kind == REQ_CHECK && frac) begin
        v.status = ST_BLOCKED;
      end else if (w == 0 || h == 0) begin
        v.status = ST_OK;
      end else if (dx < 0 || dy < 0) begin
        v.status = ST_RANGE;
      end else begin
        x0 = dx / px;
        y0 = dy / py;
        // nothing is marked unless the whole area fits
        if (x0 + w > ncol || y0 + h > nrow) begin
          v.status = ST_RANGE;
        end else begin
          for (longint r = y0; r < y0 + h; r++) begin
            for (longint c = x0; c < x0 + w; c++) begin
              if (kind == REQ_PLACE) occ_rows[r][c] = 1'b1;
              else if (occ_rows[r][c]) v.status = ST_BLOCKED;
            end
          end
        end
      end
    end else if (kind == REQ_READ || kind == REQ_SET || kind == REQ_CLEAR) begin
      if (col >= ncol || row >= nrow) begin
        v.status = ST_RANGE;
      end else if (kind == REQ_READ) begin
        v.site_occupied = occ_rows[row][col];
      end else begin
        occ_rows[row][col] = (kind == REQ_SET);
      end
    end else begin
      // unknown request kinds
      v.status = ST_RANGE;
    end
    return v;
  endfunction

  // channel monitor: results first so a same-edge request never answers itself
  always @(posedge clk) begin
    if (!rst_n) begin
      grid = '{grid_columns: 9'd256, grid_rows: 9'd256, origin_x: '0, origin_y: '0,
               site_pitch_x: 16'd1, site_pitch_y: 16'd1};
      for (int r = 0; r < MAX_ROWS; r++) occ_rows[r] = '0;
      pending_verdicts.delete();
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_verdicts.size() == 0) begin
          report_mismatch($sformatf("result %0d with no request outstanding, status %0d",
                                    results_seen, out_status));
        end else begin
          oldest = pending_verdicts.pop_front();
          if (out_status !== oldest.status)
            report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                      results_seen, out_status, oldest.status));
          if (out_site_occupied !== oldest.site_occupied)
            report_mismatch($sformatf("result %0d site_occupied %0b, expected %0b",
                                      results_seen, out_site_occupied,
                                      oldest.site_occupied));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GRID_COLUMNS: grid.grid_columns = cfg_data[8:0];
          CFG_GRID_ROWS:    grid.grid_rows    = cfg_data[8:0];
          CFG_ORIGIN_X:     grid.origin_x     = cfg_data;
          CFG_ORIGIN_Y:     grid.origin_y     = cfg_data;
          CFG_PITCH_X:      grid.site_pitch_x = cfg_data[15:0];
          CFG_PITCH_Y:      grid.site_pitch_y = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        pending_verdicts.push_back(resolve_request(in_req_type, in_loc_x, in_loc_y,
                                                   in_loc_fractional, in_cell_width,
                                                   in_cell_height, in_site_col,
                                                   in_site_row));
    end
    verdicts_waiting <= pending_verdicts.size();
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the site occupancy grid with directed and random requests under
// several grid settings, with random idle and stall on both channels; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import psog_pkg::*;

  localparam longint     EXTENT_MAX       = 1048575;
  localparam longint     LOC_MAX          = 2147483647;
  localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] CFG_SPARE_LO     = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI     = 3'd7;

  typedef struct {
    logic [2:0]         kind;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               frac;
    logic [19:0]        w;
    logic [19:0]        h;
    logic [7:0]         col;
    logic [7:0]         row;
  } request_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [2:0]           in_req_type;
  logic signed [31:0]   in_loc_x;
  logic signed [31:0]   in_loc_y;
  logic                 in_loc_fractional;
  logic [19:0]          in_cell_width;
  logic [19:0]          in_cell_height;
  logic [7:0]           in_site_col;
  logic [7:0]           in_site_row;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_status;
  logic                 out_site_occupied;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  int                   verdicts_waiting;
  int                   mismatches;

  // grid as the stimulus sees it, used to aim rectangles into range
  int       cols_eff, rows_eff;
  longint   org_x, org_y, px_eff, py_eff;
  request_t last_place;
  bit       have_last;
  bit       steady;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  placement_site_occupancy_grid_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_loc_x          (in_loc_x),
    .in_loc_y          (in_loc_y),
    .in_loc_fractional (in_loc_fractional),
    .in_cell_width     (in_cell_width),
    .in_cell_height    (in_cell_height),
    .in_site_col       (in_site_col),
    .in_site_row       (in_site_row),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_site_occupied (out_site_occupied),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  grid_occupancy_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_loc_x          (in_loc_x),
    .in_loc_y          (in_loc_y),
    .in_loc_fractional (in_loc_fractional),
    .in_cell_width     (in_cell_width),
    .in_cell_height    (in_cell_height),
    .in_site_col       (in_site_col),
    .in_site_row       (in_site_row),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_site_occupied (out_site_occupied),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .verdicts_waiting  (verdicts_waiting),
    .mismatches        (mismatches)
  );

  // result side stalls at random except during the steady stretch
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= !steady && ($urandom_range(0, 99) < 36);
  end

  // every field random, the base of all requests
  function automatic request_t noise_request();
    request_t q;
    q.kind = 3'($urandom_range(0, 7));
    q.x    = $urandom;
    q.y    = $urandom;
    q.frac = 1'($urandom_range(0, 1));
    q.w    = 20'($urandom);
    q.h    = 20'($urandom);
    q.col  = 8'($urandom);
    q.row  = 8'($urandom);
    return q;
  endfunction

  function automatic request_t site_req(input logic [2:0] kind, input logic [7:0] col,
                                        input logic [7:0] row);
    request_t q;
    q = noise_request();
    q.kind = kind;
    q.col  = col;
    q.row  = row;
    return q;
  endfunction

  function automatic request_t rect_req(input logic [2:0] kind, input logic signed [31:0] x,
                                        input logic signed [31:0] y, input logic frac,
                                        input logic [19:0] w, input logic [19:0] h);
    request_t q;
    q = noise_request();
    q.kind = kind;
    q.x    = x;
    q.y    = y;
    q.frac = frac;
    q.w    = w;
    q.h    = h;
    return q;
  endfunction

  function automatic longint fit_span(input longint a, input longint b, input longint c);
    longint m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic [31:0] fitted_origin(input longint org, input longint idx,
                                                input longint pitch);
    longint loc;
    loc = org + idx * pitch + $urandom_range(0, pitch - 1);
    if (loc > LOC_MAX) loc = org;
    return loc[31:0];
  endfunction

  function automatic logic [19:0] fitted_extent(input longint sites, input longint pitch);
    longint ext;
    ext = sites * pitch + $urandom_range(0, pitch - 1);
    if (ext > EXTENT_MAX) ext = sites * pitch;
    return ext[19:0];
  endfunction

  // rectangle aimed at the grid, now and then reaching over its edge
  function automatic request_t fitted_rect(input logic [2:0] kind, input longint span);
    request_t q;
    longint   w, h, c, r;
    q = noise_request();
    q.kind = kind;
    q.frac = ($urandom_range(0, 9) == 0);
    if (cols_eff > 0 && rows_eff > 0) begin
      w = $urandom_range(1, fit_span(span, cols_eff, EXTENT_MAX / px_eff));
      h = $urandom_range(1, fit_span(span, rows_eff, EXTENT_MAX / py_eff));
      c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, cols_eff - 1)
                                      : $urandom_range(0, cols_eff - w);
      r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, rows_eff - 1)
                                      : $urandom_range(0, rows_eff - h);
      q.x = fitted_origin(org_x, c, px_eff);
      q.y = fitted_origin(org_y, r, py_eff);
      q.w = fitted_extent(w, px_eff);
      q.h = fitted_extent(h, py_eff);
    end
    return q;
  endfunction

  function automatic logic [7:0] pick_index(input int n);
    return (n > 0) ? 8'($urandom_range(0, n - 1)) : 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [2:0] pick_site_op();
    case ($urandom_range(0, 2))
      0:       return REQ_READ;
      1:       return REQ_SET;
      default: return REQ_CLEAR;
    endcase
  endfunction

  // mostly well-aimed traffic, with rechecks of the last placement and noise
  function automatic request_t random_request();
    request_t q;
    int       roll;
    longint   span;
    roll = $urandom_range(0, 99);
    span = ($urandom_range(0, 19) == 0) ? 256 : 4;
    if (roll < 10 && have_last) begin
      q = last_place;
      q.kind = REQ_CHECK;
      q.frac = 1'b0;
    end else if (roll < 30) begin
      q = fitted_rect(REQ_CHECK, span);
    end else if (roll < 50) begin
      q = fitted_rect(REQ_PLACE, span);
      last_place = q;
      have_last = 1'b1;
    end else if (roll < 80) begin
      q = site_req(pick_site_op(), pick_index(cols_eff), pick_index(rows_eff));
    end else if (roll < 87) begin
      q = site_req(pick_site_op(), 8'($urandom), 8'($urandom));
    end else if (roll < 94) begin
      q = noise_request();
      q.kind = $urandom_range(0, 1) ? REQ_PLACE : REQ_CHECK;
    end else begin
      q = noise_request();
    end
    return q;
  endfunction

  // one request, after a random idle gap, held until taken
  task automatic issue(input request_t q);
    while (!steady && $urandom_range(0, 99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_req_type       <= q.kind;
    in_loc_x          <= q.x;
    in_loc_y          <= q.y;
    in_loc_fractional <= q.frac;
    in_cell_width     <= q.w;
    in_cell_height    <= q.h;
    in_site_col       <= q.col;
    in_site_row       <= q.row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_waiting != 0) @(posedge clk);
  endtask

  task automatic run_random(input int n);
    repeat (n) issue(random_request());
    drain();
  endtask

  // register write; valid is left high for the next write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // random upper bits above a narrow register
  function automatic logic [31:0] pad_junk(input logic [31:0] v, input int bits);
    logic [31:0] mask;
    mask = (32'd1 << bits) - 32'd1;
    return ($urandom & ~mask) | (v & mask);
  endfunction

  task automatic program_grid(input int cols, input int rows, input logic signed [31:0] ox,
                              input logic signed [31:0] oy, input int px, input int py);
    write_reg(CFG_GRID_COLUMNS, pad_junk(cols, 9));
    write_reg(CFG_GRID_ROWS, pad_junk(rows, 9));
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_PITCH_X, pad_junk(px, 16));
    write_reg(CFG_PITCH_Y, pad_junk(py, 16));
    cfg_valid <= 1'b0;
    cols_eff = ((cols & 511) > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS : (cols & 511);
    rows_eff = ((rows & 511) > DEF_MAX_ROWS) ? DEF_MAX_ROWS : (rows & 511);
    org_x    = ox;
    org_y    = oy;
    px_eff   = ((px & 65535) == 0) ? 1 : (px & 65535);
    py_eff   = ((py & 65535) == 0) ? 1 : (py & 65535);
  endtask

  // run limit
  initial begin
    #8ms;
    $display("placement_site_occupancy_grid_top verification failed");
    $finish;
  end

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_req_type       = REQ_CHECK;
    in_loc_x          = '0;
    in_loc_y          = '0;
    in_loc_fractional = 1'b0;
    in_cell_width     = '0;
    in_cell_height    = '0;
    in_site_col       = '0;
    in_site_row       = '0;
    cfg_valid         = 1'b0;
    cfg_index         = CFG_GRID_COLUMNS;
    cfg_data          = '0;
    steady            = 1'b0;
    have_last         = 1'b0;
    cols_eff          = DEF_MAX_COLUMNS;
    rows_eff          = DEF_MAX_ROWS;
    org_x             = 0;
    org_y             = 0;
    px_eff            = 1;
    py_eff            = 1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: single sites at the corners
    issue(site_req(REQ_READ, 8'd0, 8'd0));
    issue(site_req(REQ_SET, 8'd255, 8'd255));
    issue(site_req(REQ_READ, 8'd255, 8'd255));
    issue(site_req(REQ_CLEAR, 8'd255, 8'd255));
    issue(site_req(REQ_READ, 8'd255, 8'd255));
    // place then check, fractional location on check and on place
    issue(rect_req(REQ_PLACE, 0, 0, 1'b0, 20'd2, 20'd2));
    issue(rect_req(REQ_CHECK, 1, 1, 1'b0, 20'd1, 20'd1));
    issue(rect_req(REQ_CHECK, 0, 0, 1'b1, 20'd1, 20'd1));
    issue(rect_req(REQ_PLACE, 10, 10, 1'b1, 20'd1, 20'd1));
    issue(rect_req(REQ_CHECK, 10, 10, 1'b0, 20'd1, 20'd1));
    // empty rectangles wherever they lie
    issue(rect_req(REQ_CHECK, -5, -5, 1'b0, 20'd0, 20'd3));
    issue(rect_req(REQ_PLACE, 32'h7FFF_FFFF, 0, 1'b0, 20'd7, 20'd0));
    // below the origin, and a place over the edge that must not land in part
    issue(rect_req(REQ_CHECK, -1, 0, 1'b0, 20'd1, 20'd1));
    issue(rect_req(REQ_PLACE, 255, 0, 1'b0, 20'd2, 20'd1));
    issue(rect_req(REQ_CHECK, 255, 0, 1'b0, 20'd1, 20'd1));
    // a full-width row
    issue(rect_req(REQ_PLACE, 0, 100, 1'b0, 20'd256, 20'd1));
    issue(rect_req(REQ_CHECK, 0, 100, 1'b0, 20'd256, 20'd1));
    issue(site_req(REQ_READ, 8'd128, 8'd100));
    // extreme locations and extents
    issue(rect_req(REQ_CHECK, 32'h7FFF_FFFF, 5, 1'b0, 20'd1, 20'd1));
    issue(rect_req(REQ_CHECK, 32'h8000_0000, 5, 1'b0, 20'd1, 20'd1));
    issue(rect_req(REQ_CHECK, 0, 0, 1'b0, 20'hFFFFF, 20'hFFFFF));
    issue(rect_req(REQ_CHECK, 0, 0, 1'b0, 20'd256, 20'd256));
    // unknown request kinds
    for (int k = 0; k < 3; k++) issue(site_req(REQ_UNUSED_FIRST + k[2:0], 8'd0, 8'd0));
    drain();

    // small dense grid, offset origin and odd pitches
    program_grid(8, 8, -1000, 500, 3, 5);
    run_random(140);
    // wider grid at unit pitch over the same store: earlier marks stay put
    program_grid(16, 16, 0, 0, 1, 1);
    run_random(60);
    // one site, extreme origins, widest pitch
    program_grid(1, 1, 32'h7FFF_FFFF, 32'h8000_0000, 65535, 65535);
    run_random(60);
    // no columns in use, rows above the limit, zero pitches
    write_reg(CFG_SPARE_LO, $urandom);
    write_reg(CFG_SPARE_HI, $urandom);
    program_grid(0, 300, 0, 0, 0, 0);
    run_random(50);
    // long stretch without idle or stall on either side
    steady = 1'b1;
    program_grid(511, 20, 32'h8000_0000, 12345, 1, 7);
    run_random(150);
    steady = 1'b0;
    // random settings
    repeat (3) begin
      program_grid(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 511),
                   ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 511),
                   $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4000) - 2000,
                   $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4000) - 2000,
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(1, 16),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(1, 16));
      run_random(80);
    end

    // room for any stray result
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("placement_site_occupancy_grid_top verification clean");
    end else begin
      $display("placement_site_occupancy_grid_top verification failed");
    end
    $finish;
  end

endmodule
